### rtl/core/rpa_pkg.sv
// Shared codes and types for the refcounted page allocator.
package rpa_pkg;

   localparam int CMD_W     = 3;
   localparam int STATUS_W  = 2;
   localparam int CFG_W     = 13;
   localparam int CSR_IDX_W = 1;
   localparam int ADDR_W    = 32;
   localparam int OUT_CNT_W = 8;

   localparam logic [CMD_W-1:0] CMD_ALLOC = 3'd0;
   localparam logic [CMD_W-1:0] CMD_FREE  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_INC   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_DEC   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_QUERY = 3'd4;

   localparam logic [STATUS_W-1:0] STS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STS_BAD   = 2'd2;
   localparam logic [STATUS_W-1:0] STS_FULL  = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_LOWEST_PAGE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TOP_PAGE    = 1'd1;

   localparam logic [CFG_W-1:0] TOP_PAGE_RESET = 13'd4096;

   typedef enum logic [2:0] {
      ST_CLEAR = 3'b001,
      ST_IDLE  = 3'b010,
      ST_EXEC  = 3'b100
   } state_type;

endpackage

### rtl/core/refcounted_page_allocator.sv
// Page allocator: free-page stack and per-page reference counts in two RAMs.
//
//  channel | dir | handshake           | payload
//  req     | in  | req_valid/req_stall | req_command, req_address
//  rsp     | out | rsp_valid/rsp_stall | rsp_page_address, rsp_ref_count, rsp_status
//  csr     | in  | csr_valid/csr_ready | csr_index, csr_wdata
//
// Each word first reads the count RAM, and the stack RAM for an allocate, then modifies and writes back.
// The count RAM read-modify-write means the next word is taken only after writeback.
// After reset a clearing pass zeroes every entry of the count RAM, with req stalled.
// A finished result waits in the output register; a new word is taken meanwhile.
// csr writes are always taken, including during the clearing pass.
module refcounted_page_allocator #(
   parameter int PAGE_COUNT = 4096,
   parameter int PAGE_BYTES = 4096,
   parameter int COUNT_BITS = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [rpa_pkg::CMD_W-1:0]      req_command,
   input  logic [rpa_pkg::ADDR_W-1:0]     req_address,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [rpa_pkg::ADDR_W-1:0]     rsp_page_address,
   output logic [rpa_pkg::OUT_CNT_W-1:0]  rsp_ref_count,
   output logic [rpa_pkg::STATUS_W-1:0]   rsp_status,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [rpa_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rpa_pkg::CFG_W-1:0]      csr_wdata
);
   import rpa_pkg::*;

   localparam int PG_W  = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
   localparam int LVL_W = $clog2(PAGE_COUNT + 1);
   localparam int OFF_W = $clog2(PAGE_BYTES);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [LVL_W-1:0]      LVL_FULL  = LVL_W'(PAGE_COUNT);
   localparam logic [PG_W-1:0]       PG_LAST   = PG_W'(PAGE_COUNT - 1);

   state_type state_ff, state_in;

   logic [CFG_W-1:0] lowest_ff, top_ff;

   logic [PG_W-1:0]       stack_ram_ff [PAGE_COUNT];
   logic [COUNT_BITS-1:0] count_ram_ff [PAGE_COUNT];
   logic [PG_W-1:0]       stack_rd_ff;
   logic [COUNT_BITS-1:0] count_rd_ff;

   logic [LVL_W-1:0] level_ff, level_in;
   logic [PG_W-1:0]  clr_idx_ff, clr_idx_in;

   logic [CMD_W-1:0] cmd_ff;
   logic [PG_W-1:0]  page_ff;
   logic             bad_ff, empty_ff;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]    rsp_pa_ff;
   logic [OUT_CNT_W-1:0] rsp_cnt_ff;
   logic [STATUS_W-1:0]  rsp_st_ff;

   // request decode
   logic              accept, done;
   logic [31:0]       page32, limit32;
   logic              aligned, bad_free, bad_other;
   logic [LVL_W-1:0]  level_dec;

   // execute
   logic                  cnt_we, stack_we;
   logic [PG_W-1:0]       cnt_waddr;
   logic [COUNT_BITS-1:0] cnt_wdata, cnt_dec, cnt_new;
   logic [31:0]           cnt_wide;
   logic [ADDR_W-1:0]     pa_new;
   logic [STATUS_W-1:0]   st_new;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign done      = (state_ff == ST_EXEC) && (!rsp_valid_ff || !rsp_stall);
   assign csr_ready = 1'b1;

   assign page32    = 32'(req_address >> OFF_W);
   assign limit32   = (32'(top_ff) < 32'(PAGE_COUNT)) ? 32'(top_ff) : 32'(PAGE_COUNT);
   assign aligned   = (req_address[OFF_W-1:0] == '0);
   assign bad_other = (page32 >= limit32);
   assign bad_free  = !aligned || (page32 < 32'(lowest_ff)) || bad_other;
   assign level_dec = level_ff - LVL_W'(1);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (clr_idx_ff == PG_LAST) state_in = ST_IDLE;
         ST_IDLE:  if (accept) state_in = ST_EXEC;
         ST_EXEC:  if (done) state_in = ST_IDLE;
         default:  state_in = ST_CLEAR;
      endcase
   end

   assign clr_idx_in = clr_idx_ff + PG_W'(1);
   assign cnt_dec    = (count_rd_ff != '0) ? count_rd_ff - COUNT_BITS'(1) : count_rd_ff;

   always_comb begin
      cnt_we    = 1'b0;
      stack_we  = 1'b0;
      cnt_waddr = page_ff;
      cnt_wdata = '0;
      cnt_new   = '0;
      pa_new    = '0;
      st_new    = STS_OK;
      level_in  = level_ff;
      if (state_ff == ST_CLEAR) begin
         cnt_we    = 1'b1;
         cnt_waddr = clr_idx_ff;
      end else if (done) begin
         unique case (cmd_ff) inside
            CMD_ALLOC: begin
               if (empty_ff) begin
                  st_new = STS_EMPTY;
               end else begin
                  cnt_we    = 1'b1;
                  cnt_waddr = stack_rd_ff;
                  cnt_wdata = COUNT_BITS'(1);
                  cnt_new   = COUNT_BITS'(1);
                  pa_new    = ADDR_W'(32'(stack_rd_ff) << OFF_W);
                  level_in  = level_dec;
               end
            end
            CMD_FREE: begin
               if (bad_ff) begin
                  st_new = STS_BAD;
               end else begin
                  cnt_we    = 1'b1;
                  cnt_wdata = cnt_dec;
                  cnt_new   = cnt_dec;
                  if (cnt_dec == '0) begin
                     if (level_ff == LVL_FULL) begin
                        st_new = STS_FULL;
                     end else begin
                        stack_we = 1'b1;
                        level_in = level_ff + LVL_W'(1);
                     end
                  end
               end
            end
            CMD_INC, CMD_DEC, CMD_QUERY: begin
               if (bad_ff) begin
                  st_new = STS_BAD;
               end else begin
                  cnt_we = 1'b1;
                  if (cmd_ff == CMD_INC)
                     cnt_new = (count_rd_ff == COUNT_MAX) ? count_rd_ff
                                                          : count_rd_ff + COUNT_BITS'(1);
                  else if (cmd_ff == CMD_DEC)
                     cnt_new = cnt_dec;
                  else
                     cnt_new = count_rd_ff;
                  cnt_wdata = cnt_new;
               end
            end
            default: ;
         endcase
      end
   end

   assign cnt_wide = 32'(cnt_new);

   // RAMs: one write and one registered read each
   always_ff @(posedge clock) begin
      if (cnt_we) count_ram_ff[cnt_waddr] <= cnt_wdata;
      if (accept) count_rd_ff <= count_ram_ff[page32[PG_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (stack_we) stack_ram_ff[level_ff[PG_W-1:0]] <= page_ff;
      if (accept && req_command == CMD_ALLOC) stack_rd_ff <= stack_ram_ff[level_dec[PG_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff   <= req_command;
         page_ff  <= page32[PG_W-1:0];
         bad_ff   <= (req_command == CMD_FREE) ? bad_free : bad_other;
         empty_ff <= (level_ff == '0);
      end
      if (done) begin
         rsp_pa_ff  <= pa_new;
         rsp_cnt_ff <= cnt_wide[OUT_CNT_W-1:0];
         rsp_st_ff  <= st_new;
      end
   end

   assign rsp_valid_in = done || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_idx_ff   <= '0;
         level_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         lowest_ff    <= '0;
         top_ff       <= TOP_PAGE_RESET;
      end else begin
         state_ff     <= state_in;
         level_ff     <= level_in;
         rsp_valid_ff <= rsp_valid_in;
         if (state_ff == ST_CLEAR) clr_idx_ff <= clr_idx_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_LOWEST_PAGE: lowest_ff <= csr_wdata;
               CSR_TOP_PAGE:    top_ff    <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_page_address = rsp_pa_ff;
   assign rsp_ref_count    = rsp_cnt_ff;
   assign rsp_status       = rsp_st_ff;

`ifndef SYNTH
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_EXEC))
      else $error("accepted word did not enter execute");

   a_level_range: assert property (@(posedge clock) disable iff (reset)
      level_ff <= LVL_FULL)
      else $error("free stack level beyond capacity");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_st_ff == STS_EMPTY) |-> (rsp_pa_ff == '0 && rsp_cnt_ff == '0))
      else $error("empty pool result carries data");

   a_pop_level: assert property (@(posedge clock) disable iff (reset)
      (done && cmd_ff == CMD_ALLOC && !empty_ff) |=> (level_ff == $past(level_dec)))
      else $error("allocate did not pop exactly one page");
`endif

endmodule
